### hw/rtl/ptrc_pkg.sv
// Shared types and codes for the planar tile row to chunky pixel converter.
package ptrc_pkg;

    localparam int unsigned PLANES = 8;
    localparam int unsigned PIXELS = 8;

    localparam logic [1:0] MODE_NORMAL     = 2'd0;
    localparam logic [1:0] MODE_HIRES_ODD  = 2'd1;
    localparam logic [1:0] MODE_HIRES_EVEN = 2'd2;
    // spare code, converts as normal mode
    localparam logic [1:0] MODE_SPARE      = 2'd3;

    localparam logic [1:0] DEPTH_2BPP  = 2'd0;
    localparam logic [1:0] DEPTH_4BPP  = 2'd1;
    localparam logic [1:0] DEPTH_8BPP  = 2'd2;
    // spare code, converts as 8 bpp
    localparam logic [1:0] DEPTH_SPARE = 2'd3;

    localparam logic [1:0] DEPTH_RESET = DEPTH_4BPP;
    localparam logic [2:0] ROW_LAST    = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] planes_low;
        logic [31:0] planes_high;
        logic [31:0] next_tile_planes;
    } t_in_word;

    typedef struct packed {
        logic [63:0] row_pixels;
        logic        last_row;
        logic        tile_nonblank;
    } t_out_word;

endpackage

### hw/rtl/planar_tile_row_to_chunky_top.sv
// Top level of the planar tile row to chunky pixel converter.
//
// Input channel (i_valid / o_stall / i_in) takes one tile row word: mode,
// four low planes, four high planes and the low planes of the next tile.
// Output channel (o_valid / i_stall / o_out) gives eight 8-bit pixels per
// row, plus last_row on every eighth row and tile_nonblank on that row.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the depth:
// 0 = 2 bpp, 1 = 4 bpp, 2 or 3 = 8 bpp. Write it only while idle.
//
// Two register stages: an input register and a result register. An
// accepted word goes into the input register and, once the result
// register is free, through the conversion into it; o_valid then rises.
// One word per cycle sustained while the receiver does not stall; the
// conversion is a single layer of bit selection between the stages.
// When the receiver stalls, the result register holds; the input register
// takes one word if it is empty, and o_stall is high while it holds one.
// Reset (i_rst_n low, synchronous) empties both stages, sets 4 bpp and
// restarts the row counter and blank tracking at the first row of a tile.
module planar_tile_row_to_chunky_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ptrc_pkg::t_in_word  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output ptrc_pkg::t_out_word o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_data
);

    logic [1:0]          r_depth_sel;
    logic                r_s1_vld;
    ptrc_pkg::t_in_word  r_s1_word;
    logic                r_out_vld;
    ptrc_pkg::t_out_word r_out;
    logic [2:0]          r_row_cnt;
    logic                r_any;

    logic                out_free;
    logic                s1_move;
    logic [63:0]         pix;
    logic                last;
    ptrc_pkg::t_out_word n_out;

    assign o_cfg_ready = 1'b1;

    ptrc_convert u_convert (
        .i_word   (r_s1_word),
        .i_depth  (r_depth_sel),
        .o_pixels (pix)
    );

    assign out_free = !r_out_vld || !i_stall;
    assign s1_move  = r_s1_vld && out_free;
    assign o_stall  = r_s1_vld && !out_free;

    assign last                = (r_row_cnt == ptrc_pkg::ROW_LAST);
    assign n_out.row_pixels    = pix;
    assign n_out.last_row      = last;
    assign n_out.tile_nonblank = last && (r_any || (|pix));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_sel <= ptrc_pkg::DEPTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_depth_sel <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_cnt <= '0;
            r_any     <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_vld <= i_valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_move) begin
                r_row_cnt <= last ? '0 : r_row_cnt + 3'd1;
                r_any     <= last ? 1'b0 : (r_any || (|pix));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_s1_word <= i_in;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

`ifndef SYNTH
    a_nonblank_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.tile_nonblank |-> o_out.last_row)
        else $error("tile_nonblank outside last row");

    a_last_after_seventh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_row_cnt == ptrc_pkg::ROW_LAST |=> o_valid && o_out.last_row)
        else $error("eighth row not flagged last");

    a_last_pixels_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.last_row && o_out.row_pixels != 64'd0 |-> o_out.tile_nonblank)
        else $error("nonzero last row not flagged nonblank");
`endif

endmodule

### hw/rtl/ptrc_convert.sv
// Combinational bitplane to chunky conversion of one tile row.
module ptrc_convert (
    input  ptrc_pkg::t_in_word i_word,
    input  logic [1:0]         i_depth,
    output logic [63:0]        o_pixels
);

    logic [7:0] plane_b [ptrc_pkg::PLANES];
    logic [7:0] next_b  [4];
    logic [7:0] pl_en;
    logic       hires;
    logic       odd;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            plane_b[p]     = i_word.planes_low[8*p +: 8];
            plane_b[p + 4] = i_word.planes_high[8*p +: 8];
            next_b[p]      = i_word.next_tile_planes[8*p +: 8];
        end
    end

    always_comb begin
        case (i_depth)
            ptrc_pkg::DEPTH_2BPP: pl_en = 8'h03;
            ptrc_pkg::DEPTH_4BPP: pl_en = 8'h0f;
            default:              pl_en = 8'hff;
        endcase
    end

    // hires only at 2/4 bpp; code three falls back to normal
    assign hires = !pl_en[7] && (i_word.mode == ptrc_pkg::MODE_HIRES_ODD ||
                                 i_word.mode == ptrc_pkg::MODE_HIRES_EVEN);
    assign odd   = (i_word.mode == ptrc_pkg::MODE_HIRES_ODD);

    always_comb begin
        o_pixels = '0;
        for (int k = 0; k < ptrc_pkg::PIXELS; k++) begin
            for (int p = 0; p < ptrc_pkg::PLANES; p++) begin
                if (!pl_en[p]) begin
                    o_pixels[8*k + p] = 1'b0;
                end else if (hires) begin
                    // pixels 0-3 from this tile, 4-7 from the next one
                    if (k < 4) begin
                        o_pixels[8*k + p] = odd ? plane_b[p % 4][6 - 2*(k % 4)]
                                                : plane_b[p % 4][7 - 2*(k % 4)];
                    end else begin
                        o_pixels[8*k + p] = odd ? next_b[p % 4][6 - 2*(k % 4)]
                                                : next_b[p % 4][7 - 2*(k % 4)];
                    end
                end else begin
                    o_pixels[8*k + p] = plane_b[p][7 - k];
                end
            end
        end
    end

endmodule

### tb/tb_planar_tile_row_to_chunky_top.sv
// Testbench for the planar tile row to chunky converter: tile rows in, pixel rows checked.
module tb_planar_tile_row_to_chunky_top;

    localparam int TILES_PER_PHASE = 27;
    localparam int PHASES          = 6;
    localparam int DIRECTED_ROWS   = 24;
    localparam int HOLD_AT         = DIRECTED_ROWS + 4 * TILES_PER_PHASE * 8 + 40;
    localparam int HOLD_LEN        = 80;
    localparam int CYCLE_LIMIT     = 200000;

    // Tracks depth, row position and blank state; predicts one pixel word per row.
    class row_scoreboard;
        logic [1:0]          depth;
        logic [2:0]          row_cnt;
        bit                  any_set;
        ptrc_pkg::t_out_word pending_rows[$];
        int                  errors;

        function new();
            depth   = ptrc_pkg::DEPTH_RESET;
            row_cnt = '0;
            any_set = 1'b0;
            errors  = 0;
        endfunction

        function ptrc_pkg::t_out_word convert_row(ptrc_pkg::t_in_word w);
            logic [63:0]         pix;
            logic [7:0]          lo_b;
            logic [7:0]          nx_b;
            int                  nplanes;
            int                  top;
            ptrc_pkg::t_out_word r;
            pix = '0;
            case (depth)
                ptrc_pkg::DEPTH_2BPP: nplanes = 2;
                ptrc_pkg::DEPTH_4BPP: nplanes = 4;
                default:              nplanes = 8;
            endcase
            if (nplanes == 8 || (w.mode != ptrc_pkg::MODE_HIRES_ODD &&
                                 w.mode != ptrc_pkg::MODE_HIRES_EVEN)) begin
                for (int p = 0; p < nplanes; p++) begin
                    lo_b = (p < 4) ? w.planes_low[8*p +: 8] : w.planes_high[8*(p-4) +: 8];
                    for (int k = 0; k < 8; k++)
                        pix[8*k + p] = lo_b[7 - k];
                end
            end else begin
                // hires: four pixels from this tile, four from the next one
                top = (w.mode == ptrc_pkg::MODE_HIRES_ODD) ? 6 : 7;
                for (int p = 0; p < nplanes; p++) begin
                    lo_b = w.planes_low[8*p +: 8];
                    nx_b = w.next_tile_planes[8*p +: 8];
                    for (int k = 0; k < 4; k++) begin
                        pix[8*k + p]       = lo_b[top - 2*k];
                        pix[8*(k + 4) + p] = nx_b[top - 2*k];
                    end
                end
            end
            r.row_pixels    = pix;
            r.last_row      = (row_cnt == ptrc_pkg::ROW_LAST);
            r.tile_nonblank = r.last_row && (any_set || pix != '0);
            if (r.last_row) begin
                any_set = 1'b0;
                row_cnt = '0;
            end else begin
                if (pix != '0)
                    any_set = 1'b1;
                row_cnt = row_cnt + 3'd1;
            end
            return r;
        endfunction

        function void note_row(ptrc_pkg::t_in_word w);
            pending_rows.push_back(convert_row(w));
        endfunction

        function void check_row(ptrc_pkg::t_out_word got);
            ptrc_pkg::t_out_word want;
            if (pending_rows.size() == 0) begin
                $error("unexpected pixel word %h", got);
                errors++;
                return;
            end
            want = pending_rows.pop_front();
            if (got.row_pixels !== want.row_pixels) begin
                $error("row_pixels: expected %h, got %h", want.row_pixels, got.row_pixels);
                errors++;
            end
            if (got.last_row !== want.last_row) begin
                $error("last_row: expected %b, got %b", want.last_row, got.last_row);
                errors++;
            end
            if (got.tile_nonblank !== want.tile_nonblank) begin
                $error("tile_nonblank: expected %b, got %b", want.tile_nonblank, got.tile_nonblank);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    ptrc_pkg::t_in_word  i_in;
    logic                o_valid;
    logic                i_stall;
    ptrc_pkg::t_out_word o_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_data;

    row_scoreboard sb;
    int            send_idle_pct;
    int            stall_pct;
    int            rows_sent;
    int            cycle_cnt;
    int            hold_left;
    bit            held;

    planar_tile_row_to_chunky_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stall, plus one long hold-off to back the block up.
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (!held && rows_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_LEN - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Outputs are stable at the falling edge; a word seen here is taken at the next rise.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_row(o_out);
    end

    function automatic ptrc_pkg::t_in_word mk_row(logic [1:0] mode, logic [31:0] lo,
                                                  logic [31:0] hi, logic [31:0] nx);
        ptrc_pkg::t_in_word w;
        w.mode             = mode;
        w.planes_low       = lo;
        w.planes_high      = hi;
        w.next_tile_planes = nx;
        return w;
    endfunction

    task automatic send_row(input ptrc_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= w;
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        sb.note_row(w);
        rows_sent++;
    endtask

    task automatic wait_idle();
        while (sb.pending_rows.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_depth(input logic [1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.depth = d;
    endtask

    // One tile of eight rows: blank, sparse (a single set bit) or fully random low planes.
    task automatic send_tile();
        int          kind;
        int          hot;
        logic [31:0] lo;
        logic [31:0] nx;
        kind = $urandom_range(4);
        hot  = $urandom_range(7);
        for (int r = 0; r < 8; r++) begin
            case (kind)
                0: begin
                    lo = '0;
                    nx = '0;
                end
                1: begin
                    lo = (r == hot) ? (32'd1 << $urandom_range(31)) : '0;
                    nx = (r == hot && $urandom_range(1)) ? (32'd1 << $urandom_range(31)) : '0;
                end
                default: begin
                    lo = $urandom;
                    nx = $urandom;
                end
            endcase
            send_row(mk_row(2'($urandom_range(3)), lo, $urandom, nx));
        end
    endtask

    initial begin
        logic [1:0] phase_depth [PHASES];
        phase_depth = '{ptrc_pkg::DEPTH_2BPP, ptrc_pkg::DEPTH_SPARE, ptrc_pkg::DEPTH_8BPP,
                        ptrc_pkg::DEPTH_4BPP, ptrc_pkg::DEPTH_2BPP, ptrc_pkg::DEPTH_8BPP};
        sb            = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_in          = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        send_idle_pct = 18;
        stall_pct     = 51;
        rows_sent     = 0;
        cycle_cnt     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank tile at reset depth; high planes and next tile are not visible
        send_row(mk_row(ptrc_pkg::MODE_NORMAL, 32'h0, 32'hffffffff, 32'hffffffff));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_ODD, 32'h0, 32'hffffffff, 32'h0));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_EVEN, 32'h0, 32'hffffffff, 32'h0));
        send_row(mk_row(ptrc_pkg::MODE_SPARE, 32'h0, 32'hffffffff, 32'hffffffff));
        for (int i = 0; i < 4; i++)
            send_row(mk_row(ptrc_pkg::MODE_NORMAL, 32'h0, 32'h0, 32'h0));
        // every mode with extreme and alternating planes
        send_row(mk_row(ptrc_pkg::MODE_NORMAL, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_ODD, 32'hffffffff, 32'h0, 32'h0));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_EVEN, 32'h0, 32'h0, 32'hffffffff));
        send_row(mk_row(ptrc_pkg::MODE_SPARE, 32'h80402010, 32'h0, 32'hffffffff));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_ODD, 32'h55555555, 32'h0, 32'haaaaaaaa));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_EVEN, 32'h55555555, 32'h0, 32'haaaaaaaa));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_ODD, 32'haaaaaaaa, 32'h0, 32'h55555555));
        send_row(mk_row(ptrc_pkg::MODE_HIRES_EVEN, 32'haaaaaaaa, 32'h0, 32'h55555555));
        // tile whose only set pixel is on its last row
        for (int i = 0; i < 7; i++)
            send_row(mk_row(ptrc_pkg::MODE_NORMAL, 32'h0, 32'h0, 32'h0));
        send_row(mk_row(ptrc_pkg::MODE_NORMAL, 32'h00000001, 32'h0, 32'h0));

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 2) begin
                send_idle_pct = 51;
                stall_pct     = 18;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            i_valid <= 1'b0;
            wait_idle();
            write_depth(phase_depth[ph]);
            for (int t = 0; t < TILES_PER_PHASE; t++)
                send_tile();
        end
        i_valid <= 1'b0;

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.pending_rows.size() != 0) begin
            $error("%0d pixel words never arrived", sb.pending_rows.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
